### design/delta_timer_queue_assert.svh
// ----------------------------------------------------------------------------
// delta timer queue assertion macros
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DELTA_TIMER_QUEUE_ASSERT_SVH
`define DELTA_TIMER_QUEUE_ASSERT_SVH

// same-cycle implication
`define DTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Constants, codes and control types of the delta timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int TASK_ID_WIDTH = 8;
  localparam int MAX_RESULTS   = 16;

  localparam int DELTA_W      = 16;
  localparam int TASK_FIELD_W = 8;
  localparam int TASK_W       = (TASK_ID_WIDTH < TASK_FIELD_W) ? TASK_ID_WIDTH : TASK_FIELD_W;
  localparam int IDX_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W        = DELTA_W + 1;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_EXPIRED  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_DEC_HEAD,
    CMD_POP
  } store_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_INSERT,
    ST_RESP,
    ST_TICK,
    ST_POP
  } state_e;

  typedef struct packed {
    store_cmd_e         cmd;
    logic [IDX_W-1:0]   pos;
    logic [DELTA_W-1:0] nd;
    logic [TASK_W-1:0]  tid;
    logic [IDX_W-1:0]   rd_idx;
  } store_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [DELTA_W-1:0] head_delta;
    logic [DELTA_W-1:0] next_delta;
    logic [DELTA_W-1:0] rd_delta;
    logic [TASK_W-1:0]  head_task;
  } store_sts_t;

endpackage

### design/dtq_req_if.sv
// ----------------------------------------------------------------------------
// dtq_req_if
// Request channel: insert a timer or signal one elapsed tick.
// ----------------------------------------------------------------------------
interface dtq_req_if;
  import dtq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [DELTA_W-1:0]      delay_ticks;
  logic [TASK_FIELD_W-1:0] task_id;

  modport source (output valid, output op, output delay_ticks, output task_id, input ready);
  modport sink   (input valid, input op, input delay_ticks, input task_id, output ready);
endinterface

### design/dtq_rsp_if.sv
// ----------------------------------------------------------------------------
// dtq_rsp_if
// Result channel: insert status or released task.
// ----------------------------------------------------------------------------
interface dtq_rsp_if;
  import dtq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [TASK_FIELD_W-1:0] expired_task;
  logic                    last;

  modport source (output valid, output kind, output expired_task, output last, input ready);
  modport sink   (input valid, input kind, input expired_task, input last, output ready);
endinterface

### design/dtq_entry_store.sv
// ----------------------------------------------------------------------------
// dtq_entry_store
// Ordered entry registers with one-step insert shift and head pop.
// ----------------------------------------------------------------------------
`include "delta_timer_queue_assert.svh"

module dtq_entry_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtq_pkg::store_ctl_t ctl_i,
  output dtq_pkg::store_sts_t sts_o
);
  import dtq_pkg::*;

  logic [DELTA_W-1:0] delta_q [QUEUE_DEPTH];
  logic [TASK_W-1:0]  task_q  [QUEUE_DEPTH];
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   count_d;

  genvar k;
  for (k = 0; k < QUEUE_DEPTH; k++) begin : g_entry
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        case (ctl_i.cmd)
          CMD_INSERT: begin
            if (ctl_i.pos == '0) begin
              delta_q[k] <= ctl_i.nd;
              task_q[k]  <= ctl_i.tid;
            end
          end
          CMD_DEC_HEAD: delta_q[k] <= delta_q[k] - 1'b1;
          CMD_POP: begin
            delta_q[k] <= delta_q[k+1];
            task_q[k]  <= task_q[k+1];
          end
          default: ;
        endcase
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        case (ctl_i.cmd)
          CMD_INSERT: begin
            if (k == ctl_i.pos) begin
              delta_q[k] <= ctl_i.nd;
              task_q[k]  <= ctl_i.tid;
            end else if (k > ctl_i.pos && k <= count_q) begin
              // entry right after the new one gives up the new delta
              if (k == ctl_i.pos + 1) begin
                delta_q[k] <= delta_q[k-1] - ctl_i.nd;
              end else begin
                delta_q[k] <= delta_q[k-1];
              end
              task_q[k] <= task_q[k-1];
            end
          end
          CMD_POP: begin
            if (k < QUEUE_DEPTH - 1) begin
              delta_q[k] <= delta_q[(k+1) % QUEUE_DEPTH];
              task_q[k]  <= task_q[(k+1) % QUEUE_DEPTH];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    count_d = count_q;
    case (ctl_i.cmd)
      CMD_INSERT: count_d = count_q + 1'b1;
      CMD_POP:    count_d = count_q - 1'b1;
      default:    count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign sts_o.count      = count_q;
  assign sts_o.head_delta = delta_q[0];
  assign sts_o.next_delta = delta_q[1];
  assign sts_o.rd_delta   = delta_q[ctl_i.rd_idx];
  assign sts_o.head_task  = task_q[0];

  `DTQ_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `DTQ_ASSERT_IMP(a_insert_room, ctl_i.cmd == CMD_INSERT, count_q < CNT_W'(QUEUE_DEPTH), "insert into full store")
  `DTQ_ASSERT_IMP(a_pop_head_due, ctl_i.cmd == CMD_POP, count_q != '0 && delta_q[0] == '0, "pop of pending head")
  `DTQ_ASSERT_NXT(a_insert_grows, ctl_i.cmd == CMD_INSERT, count_q == $past(count_q) + 1'b1, "insert lost")

endmodule

### design/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer with one shared add/compare unit walking the delta list.
// ----------------------------------------------------------------------------
module dtq_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               req_valid_i,
  input  logic                               req_op_i,
  input  logic [dtq_pkg::DELTA_W-1:0]        req_delay_i,
  input  logic [dtq_pkg::TASK_FIELD_W-1:0]   req_task_i,
  output logic                               req_ready_o,
  input  dtq_pkg::store_sts_t                sts_i,
  output dtq_pkg::store_ctl_t                ctl_o,
  input  logic                               slot_free_i,
  output logic                               rsp_load_o,
  output dtq_pkg::kind_e                     rsp_kind_o,
  output logic [dtq_pkg::TASK_W-1:0]         rsp_task_o,
  output logic                               rsp_last_o
);
  import dtq_pkg::*;

  state_e               state_q, state_d;
  logic [DELTA_W-1:0]   delay_q;
  logic [TASK_W-1:0]    tid_q;
  logic [SUM_W-1:0]     sum_q;
  logic [CNT_W-1:0]     idx_q;
  logic [IDX_W-1:0]     pos_q;
  logic [DELTA_W-1:0]   nd_q;
  kind_e                kind_q;
  logic [RES_CNT_W-1:0] npop_q;

  logic [SUM_W-1:0] sum;
  logic             hit;
  logic             walk_end;
  logic             full;
  logic             pop_last;

  // shared unit: running sum and compare against the requested delay
  assign sum      = sum_q + SUM_W'(sts_i.rd_delta);
  assign hit      = sum >= SUM_W'(delay_q);
  assign walk_end = (idx_q == sts_i.count) || hit;
  assign full     = sts_i.count >= CNT_W'(QUEUE_DEPTH);
  assign pop_last = !((sts_i.count > CNT_W'(1)) && (sts_i.next_delta == '0) &&
                      (npop_q < RES_CNT_W'(MAX_RESULTS - 1)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (req_op_i == OP_TICK) begin
            state_d = ST_TICK;
          end else if (full) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK:   if (walk_end) state_d = ST_INSERT;
      ST_INSERT: state_d = ST_RESP;
      ST_RESP:   if (slot_free_i) state_d = ST_IDLE;
      ST_TICK: begin
        if (sts_i.count == '0) begin
          state_d = ST_IDLE;
        end else if (sts_i.head_delta == '0 || sts_i.head_delta == DELTA_W'(1)) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_POP:    if (slot_free_i && pop_last) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o  = 1'b0;
    ctl_o.cmd    = CMD_NONE;
    ctl_o.pos    = pos_q;
    ctl_o.nd     = nd_q;
    ctl_o.tid    = tid_q;
    ctl_o.rd_idx = idx_q[IDX_W-1:0];
    rsp_load_o   = 1'b0;
    rsp_kind_o   = kind_q;
    rsp_task_o   = '0;
    rsp_last_o   = 1'b1;
    case (state_q)
      ST_IDLE:   req_ready_o = 1'b1;
      ST_INSERT: ctl_o.cmd = CMD_INSERT;
      ST_RESP:   rsp_load_o = slot_free_i;
      ST_TICK: begin
        if (sts_i.count != '0 && sts_i.head_delta != '0) begin
          ctl_o.cmd = CMD_DEC_HEAD;
        end
      end
      ST_POP: begin
        rsp_load_o = slot_free_i;
        rsp_kind_o = KIND_EXPIRED;
        rsp_task_o = sts_i.head_task;
        rsp_last_o = pop_last;
        if (slot_free_i) begin
          ctl_o.cmd = CMD_POP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        // zero delay counts as one tick
        delay_q <= (req_delay_i == '0) ? DELTA_W'(1) : req_delay_i;
        tid_q   <= TASK_W'(req_task_i);
        sum_q   <= '0;
        idx_q   <= '0;
        npop_q  <= '0;
        kind_q  <= full ? KIND_FULL : KIND_ACCEPTED;
      end
      ST_WALK: begin
        if (walk_end) begin
          pos_q <= idx_q[IDX_W-1:0];
          nd_q  <= delay_q - sum_q[DELTA_W-1:0];
        end else begin
          sum_q <= sum;
          idx_q <= idx_q + 1'b1;
        end
      end
      ST_POP: begin
        if (slot_free_i) begin
          npop_q <= npop_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

### design/delta_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_timer_queue
// Hardware timer queue kept as a sorted list of tick deltas.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_i (op 0 inserts a timer of delay_ticks for
// task_id, op 1 reports one elapsed tick); results leave on rsp_o.
// An insert gives one result: accepted, or full when QUEUE_DEPTH timers are
// pending. A tick gives one expired result per released task, in expiry
// order, with last set on the final one; it gives none if nothing expires.
// One request is handled at a time; req_i.ready is high only while idle.
// Insert: an accept step, one walk step per entry passed plus one for the
// hit or the list end, a shift step and a result step; the walk is done by
// the single add/compare unit stepping through the entries. An insert into
// a full queue goes from the accept step straight to its result step.
// Tick: an accept step and a tick step, plus one pop step per released task.
// Results sit in an output register; while one is held with rsp_o.ready low,
// the walk or release sequence waits at its result step and no request is taken.
// Reset (rst_ni low, asynchronous) empties the queue at once.
// ----------------------------------------------------------------------------
module delta_timer_queue (
  input  logic clk_i,
  input  logic rst_ni,
  dtq_req_if.sink   req_i,
  dtq_rsp_if.source rsp_o
);
  import dtq_pkg::*;

  store_ctl_t        ctl;
  store_sts_t        sts;
  logic              slot_free;
  logic              rsp_load;
  kind_e             rsp_kind;
  logic [TASK_W-1:0] rsp_task;
  logic              rsp_last;

  logic                    rsp_valid_q;
  logic [1:0]              rsp_kind_q;
  logic [TASK_FIELD_W-1:0] rsp_task_q;
  logic                    rsp_last_q;

  dtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.op),
    .req_delay_i (req_i.delay_ticks),
    .req_task_i  (req_i.task_id),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .ctl_o       (ctl),
    .slot_free_i (slot_free),
    .rsp_load_o  (rsp_load),
    .rsp_kind_o  (rsp_kind),
    .rsp_task_o  (rsp_task),
    .rsp_last_o  (rsp_last)
  );

  dtq_entry_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .sts_o  (sts)
  );

  assign slot_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_kind_q <= rsp_kind;
      rsp_task_q <= TASK_FIELD_W'(rsp_task);
      rsp_last_q <= rsp_last;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.kind         = rsp_kind_q;
  assign rsp_o.expired_task = rsp_task_q;
  assign rsp_o.last         = rsp_last_q;

endmodule

### verif/timer_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_result_checker
// Watches the request and result channels of the delta timer queue, keeps
// its own sorted delta list and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module timer_result_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  input  logic                             req_ready_i,
  input  logic                             req_op_i,
  input  logic [dtq_pkg::DELTA_W-1:0]      req_delay_i,
  input  logic [dtq_pkg::TASK_FIELD_W-1:0] req_task_i,
  input  logic                             rsp_valid_i,
  input  logic                             rsp_ready_i,
  input  logic [1:0]                       rsp_kind_i,
  input  logic [dtq_pkg::TASK_FIELD_W-1:0] rsp_task_i,
  input  logic                             rsp_last_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      pending_count_o,
  output int unsigned                      expired_count_o,
  output int unsigned                      full_count_o
);
  import dtq_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    kind_e                   kind;
    logic [TASK_FIELD_W-1:0] tid;
    logic                    last;
  } timer_result_t;

  logic [DELTA_W-1:0] slot_delta [QUEUE_DEPTH];
  logic [TASK_W-1:0]  slot_task  [QUEUE_DEPTH];
  int unsigned        slot_count = 0;

  timer_result_t due_results [$];
  int unsigned   mismatches = 0;
  int unsigned   expirations = 0;
  int unsigned   rejections = 0;

  task automatic predict_request(input op_e op, input logic [DELTA_W-1:0] delay,
                                 input logic [TASK_FIELD_W-1:0] tid);
    int            want;
    int            total;
    int            prior;
    int            pos;
    int            nd;
    int            released;
    timer_result_t r;
    total    = 0;
    prior    = 0;
    released = 0;
    if (op == OP_INSERT) begin
      if (slot_count >= QUEUE_DEPTH) begin
        r = '{kind: KIND_FULL, tid: '0, last: 1'b1};
        due_results.push_back(r);
      end else begin
        want = (delay == '0) ? 1 : int'(delay);
        pos  = slot_count;
        for (int i = 0; i < slot_count; i++) begin
          total += int'(slot_delta[i]);
          if (total >= want) begin
            pos = i;
            break;
          end
          prior = total;
        end
        nd = want - prior;
        // the entry we land in front of keeps only the remainder
        if (pos < slot_count) begin
          slot_delta[pos] = slot_delta[pos] - DELTA_W'(nd);
          for (int j = slot_count; j > pos; j--) begin
            slot_delta[j] = slot_delta[j-1];
            slot_task[j]  = slot_task[j-1];
          end
        end
        slot_delta[pos] = DELTA_W'(nd);
        slot_task[pos]  = tid[TASK_W-1:0];
        slot_count++;
        r = '{kind: KIND_ACCEPTED, tid: '0, last: 1'b1};
        due_results.push_back(r);
      end
    end else if (slot_count != 0) begin
      if (slot_delta[0] != '0) begin
        slot_delta[0] = slot_delta[0] - 1'b1;
      end
      while (slot_count > 0 && slot_delta[0] == '0 && released < MAX_RESULTS) begin
        r = '{kind: KIND_EXPIRED, tid: TASK_FIELD_W'(slot_task[0]), last: 1'b0};
        due_results.push_back(r);
        released++;
        slot_count--;
        for (int j = 0; j < slot_count; j++) begin
          slot_delta[j] = slot_delta[j+1];
          slot_task[j]  = slot_task[j+1];
        end
      end
      if (released > 0) begin
        r = due_results.pop_back();
        r.last = 1'b1;
        due_results.push_back(r);
      end
    end
  endtask

  task automatic check_result();
    timer_result_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: unexpected result kind %0d task %0d last %0d", $realtime,
                 rsp_kind_i, rsp_task_i, rsp_last_i);
      end
    end else begin
      want = due_results.pop_front();
      if (want.kind == KIND_EXPIRED) expirations++;
      if (want.kind == KIND_FULL) rejections++;
      if (rsp_kind_i !== want.kind || rsp_task_i !== want.tid ||
          rsp_last_i !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result mismatch: expected kind %0d task %0d last %0d,",
                   $realtime, want.kind, want.tid, want.last);
          $display("    got kind %0d task %0d last %0d",
                   rsp_kind_i, rsp_task_i, rsp_last_i);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        predict_request(op_e'(req_op_i), req_delay_i, req_task_i);
      end
      if (rsp_valid_i && rsp_ready_i) begin
        check_result();
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= due_results.size();
    expired_count_o  <= expirations;
    full_count_o     <= rejections;
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives inserts and ticks into the delta timer queue with random gaps and
// result stalls; the timer result checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import dtq_pkg::*;

  localparam int RANDOM_ITEMS  = 125;
  localparam int DRAIN_CYCLES  = QUEUE_DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_on = 1'b1;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned expired_count;
  int unsigned full_count;
  int unsigned insert_count = 0;
  int unsigned tick_count = 0;
  int unsigned quiet_cycles = 0;

  dtq_req_if req_if ();
  dtq_rsp_if rsp_if ();

  delta_timer_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  timer_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_if.valid),
    .req_ready_i      (req_if.ready),
    .req_op_i         (req_if.op),
    .req_delay_i      (req_if.delay_ticks),
    .req_task_i       (req_if.task_id),
    .rsp_valid_i      (rsp_if.valid),
    .rsp_ready_i      (rsp_if.ready),
    .rsp_kind_i       (rsp_if.kind),
    .rsp_task_i       (rsp_if.expired_task),
    .rsp_last_i       (rsp_if.last),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .expired_count_o  (expired_count),
    .full_count_o     (full_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side stalls
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= !idle_on || ($urandom_range(99) >= 9);
    end
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_request(input op_e op, input logic [DELTA_W-1:0] delay,
                              input logic [TASK_FIELD_W-1:0] tid);
    while (idle_on && $urandom_range(99) < 9) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.delay_ticks <= delay;
    req_if.task_id     <= tid;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    if (op == OP_INSERT) insert_count++;
    else tick_count++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    logic [DELTA_W-1:0]      delay;
    logic [TASK_FIELD_W-1:0] tid;
    int unsigned             pick;
    tid  = TASK_FIELD_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 85) delay = DELTA_W'($urandom_range(24, 1));
    else if (pick < 95) delay = DELTA_W'($urandom_range(65535));
    else delay = ($urandom_range(1) == 0) ? '0 : '1;
    // ticks carry random filler in the ignored fields
    if ($urandom_range(99) < 55) send_request(OP_TICK, delay, tid);
    else send_request(OP_INSERT, delay, tid);
  endtask

  initial begin
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_INSERT;
    req_if.delay_ticks <= '0;
    req_if.task_id     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on empty queue, zero delay, tie ordering
    send_request(OP_TICK, 16'h0000, 8'h00);
    send_request(OP_INSERT, 16'h0000, 8'h00);
    send_request(OP_INSERT, 16'h0001, 8'hFF);
    send_request(OP_TICK, 16'hFFFF, 8'hFF);
    send_request(OP_INSERT, 16'hFFFF, 8'hAA);
    send_request(OP_INSERT, 16'h0003, 8'h55);
    send_request(OP_INSERT, 16'h0003, 8'h5A);
    // head still above zero after the decrement
    send_request(OP_TICK, 16'h0000, 8'h00);
    for (int i = 0; i < QUEUE_DEPTH - 3; i++) begin
      send_request(OP_INSERT, DELTA_W'(i + 2), TASK_FIELD_W'(8'h10 + i));
    end
    // queue full now
    send_request(OP_INSERT, 16'h0005, 8'h77);
    repeat (3) send_request(OP_TICK, 16'h0000, 8'h00);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 40 && n < 100);
      if (n == 75) wait_drained();
      send_random_request();
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d inserts and %0d ticks: %0d expirations, %0d full rejections",
             insert_count, tick_count, expired_count, full_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_count, pending_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
